[design/rae_pkg.sv]
// Shared types, constants and width helpers for the RMS amplitude estimator.
package rae_pkg;

    localparam int MAX_SAMPLES_DEFAULT = 4096;
    localparam int QUEUE_DEPTH         = 2;
    localparam int SAMPLE_W            = 16;
    localparam int AMP_W               = 16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_item_t;

    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic             overflow;
    } out_item_t;

    // sample count, able to hold max_samples itself
    function automatic int cnt_width(input int max_samples);
        return $clog2(max_samples + 1);
    endfunction

    // signed running sum: |sum| <= 2^15 * max_samples
    function automatic int sum_width(input int max_samples);
        return SAMPLE_W + $clog2(max_samples);
    endfunction

    // sum of squares: each square <= 2^30
    function automatic int sq_width(input int max_samples);
        return 2 * SAMPLE_W - 1 + $clog2(max_samples);
    endfunction

    // one closed block: sum, sum of squares, count, overflow flag
    function automatic int totals_width(input int max_samples);
        return sum_width(max_samples) + sq_width(max_samples) + cnt_width(max_samples) + 1;
    endfunction

endpackage

[design/rms_amplitude_estimator_core.sv]
// Top level of the RMS amplitude estimator: front end, block queue, back end.
//
// Usage:
//   sample channel: one signed Q1.14 sample per item; last_sample closes the block.
//   result channel: one item per closed block, amplitude sqrt(2*variance) as
//   unsigned Q2.14 (truncated, saturated at 65535) and an overflow flag set when
//   samples beyond MAX_SAMPLES were dropped from that block.
//   Samples are taken one per cycle while sample_stall is low. A closed block passes
//   through a two-entry queue to the back end, which runs a shift-add multiplier
//   for n*Q and for S*S, a bit-pair square root and a restoring divide, one step
//   per cycle. Loading happens in the idle state; the difference and the output
//   step have states of their own. The back end works on one block at a time
//   and takes the next block from the queue only once the last result is in
//   the output register.
//   sample_stall rises only when the queue holds two closed blocks waiting.
//   A stalled result is held steady in the output register; the back end then
//   waits with its next result and the queue fills behind it.
//   Reset clears the accumulators, the queue and the result valid.
module rms_amplitude_estimator_core #(
    parameter int MAX_SAMPLES = rae_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  rae_pkg::in_item_t  sample_item,
    output logic               result_valid,
    input  logic               result_stall,
    output rae_pkg::out_item_t result_item
);

    import rae_pkg::*;

    localparam int TW = totals_width(MAX_SAMPLES);

    logic          push;
    logic [TW-1:0] totals;
    logic          q_full;
    logic          q_pop;
    logic [TW-1:0] q_data;
    logic          q_valid;

    rae_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .push         (push),
        .totals       (totals),
        .q_full       (q_full)
    );

    rae_queue #(
        .W     (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (totals),
        .full      (q_full),
        .pop       (q_pop),
        .rd_data   (q_data),
        .not_empty (q_valid)
    );

    rae_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

[design/rae_front.sv]
// Front end: accepts samples and accumulates sum, sum of squares and count per block.
module rae_front #(
    parameter int  MAX_SAMPLES = rae_pkg::MAX_SAMPLES_DEFAULT,
    localparam int TW          = rae_pkg::totals_width(MAX_SAMPLES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  rae_pkg::in_item_t sample_item,
    output logic              push,
    output logic [TW-1:0]     totals,
    input  logic              q_full
);

    import rae_pkg::*;

    localparam int CW = cnt_width(MAX_SAMPLES);
    localparam int SW = sum_width(MAX_SAMPLES);
    localparam int QW = sq_width(MAX_SAMPLES);

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic [QW-1:0]        sq;
        logic [CW-1:0]        cnt;
        logic                 ovf;
    } totals_t;

    logic signed [SW-1:0]       sum_reg, sum_next;
    logic [QW-1:0]              sq_reg, sq_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic signed [2*SAMPLE_W-1:0] square;
    logic                       accept;
    logic                       room;
    totals_t                    tot;

    assign sample_stall = q_full;
    assign accept       = sample_valid && !q_full;
    assign room         = cnt_reg < CW'(MAX_SAMPLES);
    assign square       = sample_item.sample * sample_item.sample;

    always_comb
    begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (room)
        begin
            sum_next = sum_reg + SW'(sample_item.sample);
            sq_next  = sq_reg + QW'(square[2*SAMPLE_W-2:0]);
            cnt_next = cnt_reg + CW'(1);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // block totals include the closing item
    always_comb
    begin
        tot.sum = sum_next;
        tot.sq  = sq_next;
        tot.cnt = cnt_next;
        tot.ovf = ovf_next;
    end

    assign totals = tot;
    assign push   = accept && sample_item.last_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (sample_item.last_sample)
            begin
                sum_reg <= '0;
                sq_reg  <= '0;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
                cnt_reg <= cnt_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

[design/rae_queue.sv]
// Short queue of closed block totals between front and back end.
module rae_queue #(
    parameter int W     = 8,
    parameter int DEPTH = rae_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [FW-1:0] fill_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = fill_reg == FW'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

[design/rae_back.sv]
// Back end: n*Q - S*S, square root of twice that, divide by n, saturate, result register.
module rae_back #(
    parameter int  MAX_SAMPLES = rae_pkg::MAX_SAMPLES_DEFAULT,
    localparam int TW          = rae_pkg::totals_width(MAX_SAMPLES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic [TW-1:0]      q_data,
    output logic               result_valid,
    input  logic               result_stall,
    output rae_pkg::out_item_t result_item
);

    import rae_pkg::*;

    localparam int CW   = cnt_width(MAX_SAMPLES);
    localparam int SW   = sum_width(MAX_SAMPLES);
    localparam int QW   = sq_width(MAX_SAMPLES);
    localparam int AW   = CW + QW;
    localparam int PW   = ((AW > 2 * SW) ? AW : 2 * SW) + 1;
    localparam int XW   = PW + (PW % 2);
    localparam int RW   = XW / 2;
    localparam int RMW  = RW + 3;
    localparam int CTW  = $clog2(PW + 1);

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic [QW-1:0]        sq;
        logic [CW-1:0]        cnt;
        logic                 ovf;
    } totals_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL_A = 7'b0000010,
        ST_MUL_B = 7'b0000100,
        ST_DIFF  = 7'b0001000,
        ST_SQRT  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CTW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]   n_reg, n_next;
    logic            ovf_reg, ovf_next;
    logic [PW-1:0]   mcand_reg, mcand_next;
    logic [SW-1:0]   mplier_reg, mplier_next;
    logic [PW-1:0]   acc_reg, acc_next;
    logic [PW-1:0]   prod_a_reg, prod_a_next;
    logic [XW-1:0]   xs_reg, xs_next;
    logic [RMW-1:0]  rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   drem_reg, drem_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;

    totals_t         tot;
    logic [SW-1:0]   mag;
    logic [PW-1:0]   acc_sum;
    logic [PW-1:0]   diff;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic [CW:0]     dpart;
    logic            qbit;
    logic            slot_free;

    assign tot     = q_data;
    assign mag     = tot.sum[SW-1] ? SW'(~tot.sum + SW'(1)) : SW'(tot.sum);
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign diff    = (prod_a_reg > acc_reg) ? prod_a_reg - acc_reg : '0;

    // one result bit of the root per step, two radicand bits in
    assign rem_sh  = {rem_reg[RMW-3:0], xs_reg[XW-1:XW-2]};
    assign trial   = RMW'({root_reg, 2'b01});

    // restoring division, one quotient bit per step
    assign dpart   = {drem_reg, root_reg[RW-1]};
    assign qbit    = dpart >= (CW + 1)'(n_reg);

    assign slot_free = !out_valid_reg || !result_stall;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        prod_a_next    = prod_a_reg;
        xs_next        = xs_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    n_next      = tot.cnt;
                    ovf_next    = tot.ovf;
                    mcand_next  = PW'(tot.sq);
                    mplier_next = SW'(tot.cnt);
                    acc_next    = '0;
                    prod_a_next = PW'(mag);
                    cnt_next    = CTW'(CW);
                    state_next  = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CTW'(1);
                if (cnt_reg == CTW'(1))
                begin
                    // magnitude of the sum was parked in prod_a_reg
                    mcand_next  = prod_a_reg;
                    mplier_next = prod_a_reg[SW-1:0];
                    prod_a_next = acc_sum;
                    acc_next    = '0;
                    cnt_next    = CTW'(SW);
                    state_next  = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CTW'(1);
                if (cnt_reg == CTW'(1))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                xs_next    = XW'({diff, 1'b0});
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CTW'(RW);
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                xs_next  = xs_reg << 2;
                cnt_next = cnt_reg - CTW'(1);
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                if (cnt_reg == CTW'(1))
                begin
                    drem_next  = '0;
                    cnt_next   = CTW'(RW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // root_reg shifts out dividend bits and takes in quotient bits
                drem_next = qbit ? CW'(dpart - (CW + 1)'(n_reg)) : dpart[CW-1:0];
                root_next = {root_reg[RW-2:0], qbit};
                cnt_next  = cnt_reg - CTW'(1);
                if (cnt_reg == CTW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    if (n_reg == '0)
                    begin
                        out_next.amplitude = '0;
                    end
                    else if (|root_reg[RW-1:AMP_W])
                    begin
                        out_next.amplitude = '1;
                    end
                    else
                    begin
                        out_next.amplitude = root_reg[AMP_W-1:0];
                    end
                    out_next.overflow = ovf_reg;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        ovf_reg    <= ovf_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        prod_a_reg <= prod_a_next;
        xs_reg     <= xs_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

[design/rae_checker.sv]
// Port-level checks for the RMS amplitude estimator, bound to the top level.
module rae_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input rae_pkg::in_item_t  sample_item,
    input logic               result_valid,
    input logic               result_stall,
    input rae_pkg::out_item_t result_item
);

    logic       last_in;
    logic       res_out;
    logic [3:0] open_reg;

    assign last_in = sample_valid && !sample_stall && sample_item.last_sample;
    assign res_out = result_valid && !result_stall;

    // closed blocks whose result has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else if (last_in && !res_out)
        begin
            open_reg <= open_reg + 4'd1;
        end
        else if (res_out && !last_in)
        begin
            open_reg <= open_reg - 4'd1;
        end
    end

    a_held_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("result item changed while stalled");

    a_no_valid_in_reset: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_result_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> open_reg != 4'd0)
        else $error("result without a closed block");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_in && open_reg == 4'd0 |=> !result_valid)
        else $error("result appeared one cycle after closing item");

endmodule

bind rms_amplitude_estimator_core rae_checker u_rae_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
